[design/wrf_pkg.sv]
`default_nettype none
package wrf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_RADIUS = 4;
    localparam int MAX_HEIGHT = 4096;
    localparam int WIN_SIDE   = 2 * MAX_RADIUS + 1;
    localparam int WIN_N      = WIN_SIDE * WIN_SIDE;
    localparam int LINES      = 2 * MAX_RADIUS;

    localparam int PIX_W  = 24;
    localparam int CH_W   = 8;
    localparam int SUM_W  = 10;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WID_W  = 11;
    localparam int HGT_W  = 13;
    localparam int RAD_W  = 3;
    localparam int RANK_W = 7;
    localparam int SIDE_W = $clog2(WIN_SIDE + 1);
    localparam int CNT_W  = $clog2(WIN_N + 1);
    localparam int IDX_W  = $clog2(WIN_N);

    typedef enum logic [1:0] {
        REG_IMG_WIDTH,
        REG_IMG_HEIGHT,
        REG_RADIUS,
        REG_RANK
    } t_reg_idx;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic [WID_W-1:0]  width;
        logic [HGT_W-1:0]  height;
        logic [RAD_W-1:0]  radius;
        logic [SIDE_W-1:0] last;
        logic [CNT_W-1:0]  rank;
    } t_cfg;

    typedef struct packed {
        t_pix [WIN_N-1:0]  win;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              last;
    } t_job;

    typedef enum logic {
        F_IDLE,
        F_UPD
    } t_fstate;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CNT,
        B_PICK
    } t_bstate;

    function automatic logic [SUM_W-1:0] pix_sum(input t_pix p);
        return SUM_W'(p[7:0]) + SUM_W'(p[15:8]) + SUM_W'(p[23:16]);
    endfunction

endpackage
`default_nettype wire

[design/wrf_pix_if.sv]
`default_nettype none
interface wrf_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;

    modport source (output valid, chan0, chan1, chan2, input ready);
    modport sink   (input valid, chan0, chan1, chan2, output ready);
endinterface
`default_nettype wire

[design/wrf_res_if.sv]
`default_nettype none
interface wrf_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_chan0;
    logic [7:0]  out_chan1;
    logic [7:0]  out_chan2;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic        frame_last;

    modport source (output valid, out_chan0, out_chan1, out_chan2, out_row, out_col,
                    frame_last, input ready);
    modport sink   (input valid, out_chan0, out_chan1, out_chan2, out_row, out_col,
                    frame_last, output ready);
endinterface
`default_nettype wire

[design/wrf_front.sv]
`default_nettype none
module wrf_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wrf_pkg::t_cfg   i_cfg,
    wrf_pix_if.sink         i_pix,
    output logic            o_job_valid,
    output wrf_pkg::t_job   o_job,
    input  wire             i_job_ready
);
    import wrf_pkg::*;

    t_fstate r_state, n_state;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    t_pix r_px;
    logic [LINES-1:0][PIX_W-1:0] r_ld;
    logic [LINES*PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [WIN_SIDE-1:0][WIN_SIDE-1:0][PIX_W-1:0] r_win, n_win;
    logic [LINES-1:0][PIX_W-1:0] w_wr_col;

    logic w_accept, w_interior, w_go, w_col_end, w_row_end;

    assign w_accept   = i_pix.valid && (r_state == F_IDLE);
    assign w_interior = (r_row >= ROW_W'(i_cfg.last)) && (r_col >= COL_W'(i_cfg.last));
    assign w_go       = (r_state == F_UPD) && (!w_interior || i_job_ready);
    assign w_col_end  = (WID_W'(r_col) + WID_W'(1)) >= i_cfg.width;
    assign w_row_end  = (HGT_W'(r_row) + HGT_W'(1)) >= i_cfg.height;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (w_accept) n_state = F_UPD;
            F_UPD:  if (w_go) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_pix.ready = (r_state == F_IDLE);
        o_job_valid = (r_state == F_UPD) && w_interior;
        o_job.win   = n_win;
        o_job.row   = r_row - ROW_W'(i_cfg.radius);
        o_job.col   = r_col - COL_W'(i_cfg.radius);
        o_job.last  = w_row_end && w_col_end;
    end

    // window slide and new right column
    always_comb begin
        n_win = r_win;
        for (int wr = 0; wr < WIN_SIDE; wr++) begin
            for (int wc = 0; wc < WIN_SIDE; wc++) begin
                if (SIDE_W'(wr) <= i_cfg.last && SIDE_W'(wc) < i_cfg.last) begin
                    n_win[wr][wc] = r_win[wr][wc+1 < WIN_SIDE ? wc+1 : wc];
                end else if (SIDE_W'(wc) == i_cfg.last && SIDE_W'(wr) < i_cfg.last) begin
                    n_win[wr][wc] = r_ld[wr < LINES ? wr : 0];
                end else if (SIDE_W'(wc) == i_cfg.last && SIDE_W'(wr) == i_cfg.last) begin
                    n_win[wr][wc] = r_px;
                end
            end
        end
    end

    // column of the line stores moves up one row
    always_comb begin
        w_wr_col = r_ld;
        for (int k = 0; k < LINES; k++) begin
            if (SIDE_W'(k + 1) < i_cfg.last) begin
                w_wr_col[k] = r_ld[k+1 < LINES ? k+1 : k];
            end else if (SIDE_W'(k + 1) == i_cfg.last) begin
                w_wr_col[k] = r_px;
            end
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_go) begin
            if (w_col_end) begin
                n_col = '0;
                n_row = w_row_end ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_px <= {i_pix.chan2, i_pix.chan1, i_pix.chan0};
            r_ld <= r_mem[r_col];
        end
        if (w_go) begin
            r_mem[r_col] <= w_wr_col;
            r_win        <= n_win;
        end
    end

endmodule
`default_nettype wire

[design/wrf_queue.sv]
`default_nettype none
module wrf_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  wrf_pkg::t_job   i_data,
    output logic            o_ready,
    output logic            o_valid,
    output wrf_pkg::t_job   o_data,
    input  wire             i_pop
);
    import wrf_pkg::*;

    t_job r_mem [2];
    logic r_wr, r_rd;
    logic [1:0] r_count;
    logic w_push, w_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop) r_rd <= ~r_rd;
            r_count <= r_count + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_data;
    end

endmodule
`default_nettype wire

[design/wrf_back.sv]
`default_nettype none
module wrf_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wrf_pkg::t_cfg   i_cfg,
    input  wire             i_job_valid,
    input  wrf_pkg::t_job   i_job,
    output logic            o_job_ready,
    wrf_res_if.source       o_res
);
    import wrf_pkg::*;

    t_bstate r_state, n_state;
    t_pix [WIN_N-1:0] r_pix;
    logic [WIN_N-1:0][SUM_W-1:0] r_sum, w_sum;
    logic [WIN_N-1:0][CNT_W-1:0] r_cnt, n_cnt;
    logic [SIDE_W-1:0] r_jr, r_jc;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic r_last;
    logic r_ovalid;
    t_pix r_opix, w_sel;
    logic [ROW_W-1:0] r_orow;
    logic [COL_W-1:0] r_ocol;
    logic r_olast;

    logic [IDX_W-1:0] w_jidx;
    logic [SUM_W-1:0] w_sj;
    logic w_load, w_scan_end, w_emit;

    assign w_load     = (r_state == B_IDLE) && i_job_valid;
    assign w_scan_end = (r_jr == i_cfg.last) && (r_jc == i_cfg.last);
    assign w_emit     = (r_state == B_PICK) && (!r_ovalid || o_res.ready);
    assign w_jidx     = IDX_W'(r_jr) * IDX_W'(WIN_SIDE) + IDX_W'(r_jc);
    assign w_sj       = r_sum[w_jidx];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (i_job_valid) n_state = B_CNT;
            B_CNT:  if (w_scan_end) n_state = B_PICK;
            B_PICK: if (w_emit) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_job_ready      = (r_state == B_IDLE);
        o_res.valid      = r_ovalid;
        o_res.out_chan0  = r_opix[7:0];
        o_res.out_chan1  = r_opix[15:8];
        o_res.out_chan2  = r_opix[23:16];
        o_res.out_row    = r_orow;
        o_res.out_col    = r_ocol;
        o_res.frame_last = r_olast;
    end

    always_comb begin
        for (int i = 0; i < WIN_N; i++) w_sum[i] = pix_sum(i_job.win[i]);
    end

    // one compare per window place against the scanned sum
    always_comb begin
        n_cnt = r_cnt;
        for (int wr = 0; wr < WIN_SIDE; wr++) begin
            for (int wc = 0; wc < WIN_SIDE; wc++) begin
                if (w_sj < r_sum[wr*WIN_SIDE+wc] ||
                    (w_sj == r_sum[wr*WIN_SIDE+wc] &&
                     (r_jr < SIDE_W'(wr) || (r_jr == SIDE_W'(wr) && r_jc < SIDE_W'(wc)))))
                begin
                    n_cnt[wr*WIN_SIDE+wc] = r_cnt[wr*WIN_SIDE+wc] + CNT_W'(1);
                end
            end
        end
    end

    // counts are distinct, so exactly one place matches the rank
    always_comb begin
        w_sel = '0;
        for (int wr = 0; wr < WIN_SIDE; wr++) begin
            for (int wc = 0; wc < WIN_SIDE; wc++) begin
                if (SIDE_W'(wr) <= i_cfg.last && SIDE_W'(wc) <= i_cfg.last &&
                    r_cnt[wr*WIN_SIDE+wc] == i_cfg.rank) begin
                    w_sel = w_sel | r_pix[wr*WIN_SIDE+wc];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
            r_jr     <= '0;
            r_jc     <= '0;
        end else begin
            r_state <= n_state;
            if (w_emit) r_ovalid <= 1'b1;
            else if (o_res.ready) r_ovalid <= 1'b0;
            if (w_load) begin
                r_jr <= '0;
                r_jc <= '0;
            end else if (r_state == B_CNT) begin
                if (r_jc == i_cfg.last) begin
                    r_jc <= '0;
                    r_jr <= r_jr + SIDE_W'(1);
                end else begin
                    r_jc <= r_jc + SIDE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_pix  <= i_job.win;
            r_sum  <= w_sum;
            r_cnt  <= '0;
            r_row  <= i_job.row;
            r_col  <= i_job.col;
            r_last <= i_job.last;
        end else if (r_state == B_CNT) begin
            r_cnt <= n_cnt;
        end
        if (w_emit) begin
            r_opix <= w_sel;
            r_orow <= r_row;
            r_ocol <= r_col;
            r_olast <= r_last;
        end
    end

endmodule
`default_nettype wire

[design/window_rank_filter_top.sv]
// path: a taken word is registered with its line store column; an interior pixel's
//   window, n = (2r+1)^2 places, goes through the queue to the back end's rank scan
// flow: the front takes a new pixel only after the line store write-back of the last;
//   the back end takes a new window only after its rank scan and output of the last
// reset: synchronous active low; clears counters, queue and handshakes and
//   loads default registers; line store and window are not cleared
`default_nettype none
module window_rank_filter_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    wrf_pix_if.sink     i_pix,
    wrf_res_if.source   o_res,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import wrf_pkg::*;

    // configuration registers, raw as written
    logic [WID_W-1:0]  r_width;
    logic [HGT_W-1:0]  r_height;
    logic [RAD_W-1:0]  r_radius;
    logic [RANK_W-1:0] r_rank;

    t_cfg w_cfg;
    t_reg_idx w_idx;
    logic [SIDE_W-1:0] w_side;
    logic [2*SIDE_W-1:0] w_n;
    logic w_wr;

    // job path between front and back
    logic w_fj_valid, w_fj_ready, w_bj_valid, w_bj_ready;
    t_job w_fjob, w_bjob;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WID_W'(MAX_WIDTH);
            r_height <= HGT_W'(1024);
            r_radius <= RAD_W'(1);
            r_rank   <= RANK_W'(4);
        end else if (w_wr) begin
            unique case (w_idx)
                REG_IMG_WIDTH:  r_width  <= pwdata[WID_W-1:0];
                REG_IMG_HEIGHT: r_height <= pwdata[HGT_W-1:0];
                REG_RADIUS:     r_radius <= pwdata[RAD_W-1:0];
                REG_RANK:       r_rank   <= pwdata[RANK_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (w_idx)
            REG_IMG_WIDTH:  prdata = 32'(r_width);
            REG_IMG_HEIGHT: prdata = 32'(r_height);
            REG_RADIUS:     prdata = 32'(r_radius);
            REG_RANK:       prdata = 32'(r_rank);
            default:        prdata = '0;
        endcase
    end

    // clamp to the supported range
    always_comb begin
        w_cfg.width = r_width;
        if (r_width == '0) w_cfg.width = WID_W'(1);
        else if (r_width > WID_W'(MAX_WIDTH)) w_cfg.width = WID_W'(MAX_WIDTH);
        w_cfg.height = r_height;
        if (r_height == '0) w_cfg.height = HGT_W'(1);
        else if (r_height > HGT_W'(MAX_HEIGHT)) w_cfg.height = HGT_W'(MAX_HEIGHT);
        w_cfg.radius = (r_radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : r_radius;
        w_cfg.last   = SIDE_W'(w_cfg.radius) << 1;
        w_side       = w_cfg.last + SIDE_W'(1);
        w_n          = (2*SIDE_W)'(w_side) * (2*SIDE_W)'(w_side);
        // rank at or past the window size picks the largest
        w_cfg.rank   = (CNT_W'(r_rank) >= w_n[CNT_W-1:0]) ? w_n[CNT_W-1:0] - CNT_W'(1)
                                                            : CNT_W'(r_rank);
    end

    // front: line stores and sliding window
    wrf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_pix       (i_pix),
        .o_job_valid (w_fj_valid),
        .o_job       (w_fjob),
        .i_job_ready (w_fj_ready)
    );

    // two window snapshots decouple front from back
    wrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fj_valid),
        .i_data  (w_fjob),
        .o_ready (w_fj_ready),
        .o_valid (w_bj_valid),
        .o_data  (w_bjob),
        .i_pop   (w_bj_ready)
    );

    // back: rank scan and output register
    wrf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_job_valid (w_bj_valid),
        .i_job       (w_bjob),
        .o_job_ready (w_bj_ready),
        .o_res       (o_res)
    );

endmodule
`default_nettype wire

[tb/tb_window_rank_filter_top.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_window_rank_filter_top;
    import wrf_pkg::*;

    // one expected filter result
    typedef struct {
        logic [7:0]  c0;
        logic [7:0]  c1;
        logic [7:0]  c2;
        logic [11:0] row;
        logic [9:0]  col;
        logic        last;
    } t_rank_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    wrf_pix_if pix_if ();
    wrf_res_if res_if ();

    window_rank_filter_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // pixels waiting for the driver and results waiting for the monitor
    t_pix      pix_queue[$];
    t_rank_res rank_queue[$];
    int        err_count;
    int        idle_pct;
    int        pix_sent;
    int        res_expected;

    // shadow of the block: line stores, window, position and registers
    t_pix        line_mem [LINES*MAX_WIDTH];
    t_pix        win_mem  [WIN_SIDE*WIN_SIDE];
    int unsigned row_pos;
    int unsigned col_pos;
    logic [10:0] cfg_width;
    logic [12:0] cfg_height;
    logic [2:0]  cfg_radius;
    logic [6:0]  cfg_rank;

    always #10 i_clk = ~i_clk;

    // push one pixel and work out the ranked result it causes, if any
    task automatic send_pixel(input t_pix px);
        int unsigned w, h, r, side, n, rk, lst, col, row, pick, cnt;
        int unsigned sums [WIN_N];
        t_pix        sel;
        t_rank_res   res;
        w = cfg_width;
        h = cfg_height;
        r = cfg_radius;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h < 1) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        if (r > MAX_RADIUS) r = MAX_RADIUS;
        side = 2*r + 1;
        n = side*side;
        rk = cfg_rank;
        if (rk > n - 1) rk = n - 1;
        lst = 2*r;
        row = row_pos;
        col = (col_pos < MAX_WIDTH) ? col_pos : MAX_WIDTH - 1;
        pix_queue.push_back(px);
        pix_sent++;
        // slide the window left and load the new right column
        for (int wr = 0; wr < side; wr++)
            for (int wc = 0; wc + 1 < side; wc++)
                win_mem[wr*WIN_SIDE + wc] = win_mem[wr*WIN_SIDE + wc + 1];
        for (int k = 0; k < lst; k++)
            win_mem[k*WIN_SIDE + lst] = line_mem[k*MAX_WIDTH + col];
        win_mem[lst*WIN_SIDE + lst] = px;
        // this column of the line stores moves up one row
        if (r > 0) begin
            for (int k = 0; k + 1 < lst; k++)
                line_mem[k*MAX_WIDTH + col] = line_mem[(k+1)*MAX_WIDTH + col];
            line_mem[(lst-1)*MAX_WIDTH + col] = px;
        end
        if (row >= lst && col >= lst) begin
            pick = 0;
            for (int i = 0; i < n; i++) begin
                sel = win_mem[(i/side)*WIN_SIDE + i%side];
                sums[i] = sel[7:0] + sel[15:8] + sel[23:16];
            end
            // rank by sum, ties to the earlier window place
            for (int i = 0; i < n; i++) begin
                cnt = 0;
                for (int j = 0; j < n; j++)
                    if (sums[j] < sums[i] || (sums[j] == sums[i] && j < i))
                        cnt++;
                if (cnt == rk) pick = i;
            end
            sel = win_mem[(pick/side)*WIN_SIDE + pick%side];
            res.c0 = sel[7:0];
            res.c1 = sel[15:8];
            res.c2 = sel[23:16];
            res.row = 12'(row - r);
            res.col = 10'(col - r);
            res.last = (row + 1 >= h && col + 1 >= w);
            rank_queue.push_back(res);
            res_expected++;
        end
        if (col + 1 >= w) begin
            col_pos = 0;
            row_pos = (row + 1 >= h) ? 0 : row + 1;
        end else begin
            col_pos = col + 1;
        end
    endtask

    // two-phase register write: setup, then access
    task automatic reg_write(input t_reg_idx idx, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait for the block to drain, then load a new setting
    task automatic set_frame(input int w, input int h, input int r, input int k);
        wait (pix_queue.size() == 0 && rank_queue.size() == 0);
        // border pixels leave no result, so allow the pipe to settle
        repeat (200) @(posedge i_clk);
        reg_write(REG_IMG_WIDTH, 32'(w));
        reg_write(REG_IMG_HEIGHT, 32'(h));
        reg_write(REG_RADIUS, 32'(r));
        reg_write(REG_RANK, 32'(k));
        cfg_width  = 11'(w);
        cfg_height = 13'(h);
        cfg_radius = 3'(r);
        cfg_rank   = 7'(k);
    endtask

    // random pixel: mostly uniform, some from a small set to force ties
    function automatic t_pix rand_pixel();
        t_pix p;
        p = 24'($urandom);
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(3))
                0: p = 24'h000000;
                1: p = 24'hffffff;
                2: p = 24'h102030;
                default: p = 24'h302010;
            endcase
        end
        return p;
    endfunction

    // whole frame of pixels at the current setting
    task automatic send_frame();
        int unsigned w, h;
        w = (cfg_width < 1) ? 1 : (cfg_width > MAX_WIDTH ? MAX_WIDTH : cfg_width);
        h = (cfg_height < 1) ? 1 : (cfg_height > MAX_HEIGHT ? MAX_HEIGHT : cfg_height);
        for (int unsigned i = 0; i < w*h; i++)
            send_pixel(rand_pixel());
    endtask

    // driver: a new word goes out when the slot is empty or just taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
        end else if (!pix_if.valid || pix_if.ready) begin
            if (pix_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
                t_pix p;
                p = pix_queue.pop_front();
                pix_if.valid <= 1'b1;
                pix_if.chan0 <= p[7:0];
                pix_if.chan1 <= p[15:8];
                pix_if.chan2 <= p[23:16];
            end else begin
                pix_if.valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= ($urandom_range(99) >= idle_pct);
    end

    // monitor: each taken result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (rank_queue.size() == 0) begin
                $error("result with nothing expected: row %0d col %0d",
                       res_if.out_row, res_if.out_col);
                err_count++;
            end else begin
                t_rank_res e;
                e = rank_queue.pop_front();
                if (res_if.out_chan0 !== e.c0) begin
                    $error("out_chan0 expected %0d got %0d", e.c0, res_if.out_chan0);
                    err_count++;
                end
                if (res_if.out_chan1 !== e.c1) begin
                    $error("out_chan1 expected %0d got %0d", e.c1, res_if.out_chan1);
                    err_count++;
                end
                if (res_if.out_chan2 !== e.c2) begin
                    $error("out_chan2 expected %0d got %0d", e.c2, res_if.out_chan2);
                    err_count++;
                end
                if (res_if.out_row !== e.row) begin
                    $error("out_row expected %0d got %0d", e.row, res_if.out_row);
                    err_count++;
                end
                if (res_if.out_col !== e.col) begin
                    $error("out_col expected %0d got %0d", e.col, res_if.out_col);
                    err_count++;
                end
                if (res_if.frame_last !== e.last) begin
                    $error("frame_last expected %0d got %0d", e.last, res_if.frame_last);
                    err_count++;
                end
            end
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pix_if.valid = 1'b0;
        pix_if.chan0 = '0;
        pix_if.chan1 = '0;
        pix_if.chan2 = '0;
        res_if.ready = 1'b0;
        err_count = 0;
        idle_pct = 32;
        pix_sent = 0;
        res_expected = 0;
        row_pos = 0;
        col_pos = 0;
        cfg_width = 11'd1024;
        cfg_height = 13'd1024;
        cfg_radius = 3'd1;
        cfg_rank = 7'd4;
        for (int i = 0; i < LINES*MAX_WIDTH; i++) line_mem[i] = '0;
        for (int i = 0; i < WIN_N; i++) win_mem[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: 4x4 frame, 3x3 window, median rank; extremes and ties
        set_frame(4, 4, 1, 4);
        send_pixel(24'h000000);
        send_pixel(24'hffffff);
        send_pixel(24'h0000ff);
        send_pixel(24'hff0000);
        send_pixel(24'h00ff00);
        send_pixel(24'h010101);
        send_pixel(24'h030000);
        send_pixel(24'h000300);
        send_pixel(24'h000003);
        send_pixel(24'h010101);
        send_pixel(24'hfefefe);
        send_pixel(24'h7f7f7f);
        send_pixel(24'h808080);
        send_pixel(24'h55aa00);
        send_pixel(24'haa0055);
        send_pixel(24'h00aa55);

        // largest window, top rank and rank past the end
        set_frame(9, 9, 4, 80);
        send_frame();
        set_frame(10, 9, 7, 127);
        send_frame();
        // frame smaller than the window gives nothing
        set_frame(2, 5, 2, 0);
        send_frame();

        // random frames, small sizes; a stretch with no idling
        while (pix_sent < 700) begin
            int r;
            r = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(2);
            set_frame($urandom_range(1, 12), $urandom_range(1, 10), r,
                      ($urandom_range(4) == 0) ? $urandom_range(127)
                                              : $urandom_range((2*r+1)*(2*r+1)));
            idle_pct = (pix_sent > 250 && pix_sent < 450) ? 0 : 32;
            send_frame();
        end
        idle_pct = 32;

        // zero width and height, radius and rank past the top
        set_frame(0, 0, 0, 127);
        send_frame();
        set_frame(0, 3, 7, 127);
        send_frame();

        wait (pix_queue.size() == 0 && rank_queue.size() == 0);
        repeat (200) @(posedge i_clk);
        if (err_count == 0) begin
            $display("window_rank_filter_top test passed");
        end else begin
            $display("window_rank_filter_top test failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #20ms;
        $display("window_rank_filter_top test failed");
        $finish;
    end
endmodule
`default_nettype wire
